### src/rrmc_pkg.sv
// Package for the RR interval Markov classifier.
// Holds field widths, class codes, the compare scale factors and the
// control/response structs used between the top level and the table.
`default_nettype none

package rrmc_pkg;

    // Field widths
    localparam int PEAK_W  = 32;
    localparam int IVL_W   = 16;
    localparam int AVG_W   = 16;
    localparam int CNT_W   = 16;
    localparam int CLS_W   = 2;

    // Ratio compare: 20*ivl against 23*avg (long) and 17*avg (short)
    localparam int IVL_SCALE   = 20;
    localparam int LONG_SCALE  = 23;
    localparam int SHORT_SCALE = 17;
    localparam int CMP_W       = 21;

    // Transition table geometry
    localparam int NUM_CLASSES = 3;
    localparam int TBL_DEPTH   = NUM_CLASSES * NUM_CLASSES;
    localparam int TBL_IDX_W   = $clog2(TBL_DEPTH);

    localparam logic [IVL_W-1:0] IVL_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [CLS_W-1:0] {
        CLS_REGULAR = 2'd0,
        CLS_SHORT   = 2'd1,
        CLS_LONG    = 2'd2
    } rr_class_t;

    // Command from the top level to the transition table
    typedef struct packed {
        logic      clear;   // new record: wipe previous class and counts
        logic      step;    // an interval was classed this cycle
        rr_class_t cls;     // class of that interval
    } tbl_ctrl_t;

    // Transition result for the interval being classed
    typedef struct packed {
        rr_class_t        from_cls;
        logic             valid;
        logic [CNT_W-1:0] count;
    } tbl_resp_t;

endpackage

`default_nettype wire

### src/rr_interval_markov_classifier_top.sv
// Top level of the RR interval Markov classifier: input register, peak
// tracking, output register. Uses rrmc_pkg, rrmc_classify, rrmc_trans_table.
`default_nettype none

// One R-peak time stamp per transaction in, at most one result out. An
// accepted item sits in the input register, where its interval is formed,
// classed and counted by combinational logic; its result lands in the
// output register as the item leaves. A new item is accepted every cycle as
// long as the output register drains, so throughput is then one item per
// clock; out_valid rises once the item has passed the input register and
// the output register. The first peak of a record (after reset or with
// new_record set) yields no result and never waits on the output side.
// The average_interval register is written through cfg_valid/cfg_ready,
// always ready, and should only be written while the block is idle.
module rr_interval_markov_classifier_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Configuration
    input  wire logic                         cfg_valid,
    output      logic                         cfg_ready,
    input  wire logic [rrmc_pkg::AVG_W-1:0]   average_interval,
    // Input channel
    input  wire logic                         in_valid,
    output      logic                         in_ready,
    input  wire logic [rrmc_pkg::PEAK_W-1:0]  peak_time,
    input  wire logic                         new_record,
    // Output channel
    output      logic                         out_valid,
    input  wire logic                         out_ready,
    output      logic [rrmc_pkg::IVL_W-1:0]   interval,
    output      logic [rrmc_pkg::CLS_W-1:0]   interval_class,
    output      logic [rrmc_pkg::CLS_W-1:0]   from_class,
    output      logic                         transition_valid,
    output      logic [rrmc_pkg::CNT_W-1:0]   transition_count
);
    import rrmc_pkg::*;

    logic [AVG_W-1:0]  avg_reg;

    logic              s1_valid_reg;
    logic [PEAK_W-1:0] s1_peak_reg;
    logic              s1_new_reg;

    logic [PEAK_W-1:0] last_peak_reg;
    logic              have_peak_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [IVL_W-1:0]  ivl_reg;
    rr_class_t         cls_reg;
    tbl_resp_t         resp_reg;

    logic [IVL_W-1:0]  ivl;
    rr_class_t         cls;
    tbl_ctrl_t         tbl_ctrl;
    tbl_resp_t         tbl_resp;

    logic              produces;
    logic              s1_fire;
    logic              produce_fire;
    logic              in_fire;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            avg_reg <= '0;
        else if (cfg_valid && cfg_ready)
            avg_reg <= average_interval;
    end

    // Stage handshake: an item without a result never waits on the output
    assign produces     = have_peak_reg && !s1_new_reg;
    assign s1_fire      = s1_valid_reg && (!produces || !out_valid_reg || out_ready);
    assign produce_fire = s1_fire && produces;
    assign in_ready     = !s1_valid_reg || s1_fire;
    assign in_fire      = in_valid && in_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_peak_reg <= peak_time;
            s1_new_reg  <= new_record;
        end
    end

    // Interval and class
    rrmc_classify u_classify (
        .peak_time (s1_peak_reg),
        .last_peak (last_peak_reg),
        .avg       (avg_reg),
        .ivl       (ivl),
        .cls       (cls)
    );

    // Transition counting
    always_comb
    begin
        tbl_ctrl.clear = s1_fire && s1_new_reg;
        tbl_ctrl.step  = produce_fire;
        tbl_ctrl.cls   = cls;
    end

    rrmc_trans_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tbl_ctrl),
        .resp  (tbl_resp)
    );

    // Peak tracking; a new record restarts with this peak
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_peak_reg <= '0;
            have_peak_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            last_peak_reg <= s1_peak_reg;
            have_peak_reg <= 1'b1;
        end
    end

    // Output register
    always_comb
    begin
        if (produce_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (produce_fire)
        begin
            ivl_reg  <= ivl;
            cls_reg  <= cls;
            resp_reg <= tbl_resp;
        end
    end

    assign out_valid        = out_valid_reg;
    assign interval         = ivl_reg;
    assign interval_class   = cls_reg;
    assign from_class       = resp_reg.from_cls;
    assign transition_valid = resp_reg.valid;
    assign transition_count = resp_reg.count;

    // Checks
    a_no_trans_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !transition_valid |->
            from_class == CLS_REGULAR && transition_count == '0)
        else $error("transition fields set without a counted transition");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && transition_valid |-> transition_count != '0)
        else $error("counted transition reports zero count");

    a_record_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_new_reg |=> have_peak_reg && last_peak_reg == $past(s1_peak_reg))
        else $error("new record did not store its first peak");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        produce_fire |=> out_valid)
        else $error("result lost at output register");

endmodule

`default_nettype wire

### src/rrmc_classify.sv
// Interval forming and three-way classification against the average.
// Pure combinational; depends on rrmc_pkg.
`default_nettype none

module rrmc_classify (
    input  wire logic [rrmc_pkg::PEAK_W-1:0] peak_time,
    input  wire logic [rrmc_pkg::PEAK_W-1:0] last_peak,
    input  wire logic [rrmc_pkg::AVG_W-1:0]  avg,
    output      logic [rrmc_pkg::IVL_W-1:0]  ivl,
    output      rrmc_pkg::rr_class_t         cls
);
    import rrmc_pkg::*;

    logic [PEAK_W-1:0] diff;
    logic [CMP_W-1:0]  ivl_scaled;
    logic [CMP_W-1:0]  long_lim;
    logic [CMP_W-1:0]  short_lim;

    // Wrapping difference, saturated to the interval width
    assign diff = peak_time - last_peak;
    assign ivl  = (|diff[PEAK_W-1:IVL_W]) ? IVL_MAX : diff[IVL_W-1:0];

    // Constant-factor scaling; all products fit in CMP_W bits
    assign ivl_scaled = CMP_W'(ivl) * CMP_W'(IVL_SCALE);
    assign long_lim   = CMP_W'(avg) * CMP_W'(LONG_SCALE);
    assign short_lim  = CMP_W'(avg) * CMP_W'(SHORT_SCALE);

    // Long takes priority (zero average gives long)
    always_comb
    begin
        if (ivl_scaled >= long_lim)
            cls = CLS_LONG;
        else if (ivl_scaled <= short_lim)
            cls = CLS_SHORT;
        else
            cls = CLS_REGULAR;
    end

endmodule

`default_nettype wire

### src/rrmc_trans_table.sv
// 3x3 saturating transition count table with previous-class tracking.
// Nine registered counters; depends on rrmc_pkg.
`default_nettype none

module rrmc_trans_table (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rrmc_pkg::tbl_ctrl_t ctrl,
    output      rrmc_pkg::tbl_resp_t resp
);
    import rrmc_pkg::*;

    logic [CNT_W-1:0]     count_reg [TBL_DEPTH];
    rr_class_t            last_class_reg;
    logic                 have_class_reg;

    logic [TBL_IDX_W-1:0] idx;
    logic [CNT_W-1:0]     cur;
    logic [CNT_W-1:0]     count_next;
    logic                 counting;

    // Row is the previous class, column the current one
    assign idx = TBL_IDX_W'(last_class_reg) * TBL_IDX_W'(NUM_CLASSES) + TBL_IDX_W'(ctrl.cls);
    assign cur = count_reg[idx];
    assign count_next = (cur == CNT_MAX) ? cur : cur + CNT_W'(1);
    assign counting = have_class_reg && !ctrl.clear;

    always_comb
    begin
        resp.valid    = counting;
        resp.from_cls = counting ? last_class_reg : CLS_REGULAR;
        resp.count    = counting ? count_next : '0;
    end

    // Counter array
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TBL_DEPTH; i++)
                count_reg[i] <= '0;
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < TBL_DEPTH; i++)
                count_reg[i] <= '0;
        end
        else if (ctrl.step && have_class_reg)
        begin
            count_reg[idx] <= count_next;
        end
    end

    // Previous class
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_class_reg <= CLS_REGULAR;
            have_class_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            last_class_reg <= CLS_REGULAR;
            have_class_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            last_class_reg <= ctrl.cls;
            have_class_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire
